// File: rtl/core/assert_macros.svh
// Assertion macros for the scanner RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every rising clock edge outside reset.
`define SCN_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define SCN_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

// File: rtl/core/sts_pkg.sv
// Package for the source token scanner: payload and work structs, scan modes, token codes, helpers.
// Depends on nothing.
`timescale 1ns / 1ps
package sts_pkg;

  localparam int unsigned OffsetBitsDef = 24;
  localparam int unsigned LineBitsDef   = 16;
  localparam int unsigned DepthBitsDef  = 8;
  localparam int unsigned FieldOffBits  = 24;
  localparam int unsigned FieldLineBits = 16;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [5:0]              token_type;
    logic [FieldOffBits-1:0] start_offset;
    logic [FieldOffBits-1:0] token_length;
    logic [FieldLineBits-1:0] line_number;
    logic [1:0]              error_kind;
    logic                    last_of_run;
  } out_item_t;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_INT, M_DOT, M_FRAC, M_STR, M_LINEC, M_BLOCKC,
    M_SLASH, M_BANG, M_EQ, M_LT, M_GT, M_DONE
  } mode_e;

  localparam logic [5:0] T_DOT     = 6'd7;
  localparam logic [5:0] T_SLASH   = 6'd12;
  localparam logic [5:0] T_BANG    = 6'd15;
  localparam logic [5:0] T_EQUAL   = 6'd17;
  localparam logic [5:0] T_GREATER = 6'd19;
  localparam logic [5:0] T_LESS    = 6'd21;
  localparam logic [5:0] T_IDENT   = 6'd23;
  localparam logic [5:0] T_STRING  = 6'd24;
  localparam logic [5:0] T_NUMBER  = 6'd25;
  localparam logic [5:0] T_ERROR   = 6'd40;
  localparam logic [5:0] T_EOF     = 6'd41;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_UNEXP = 2'd1;
  localparam logic [1:0] ERR_UNTERM = 2'd2;

  // Work for one byte, handed from the classifier to the emitter.
  typedef struct packed {
    logic       ev_valid;   // record a: flush of a pending token
    logic [5:0] a_type;
    logic       a_use_begin; // start from token_begin
    logic       a_dot_split; // number ending before a trailing dot
    logic [1:0] a_len_kind;  // 0 zero,1 one,2 two,3 span
    logic [1:0] a_err;
    logic       b_valid;    // record b: new token or closing token
    logic [5:0] b_type;
    logic       dot_valid;  // trailing dot of a number: at position-1, length 1
    logic [1:0] b_len_kind;
    logic [1:0] b_err;
    logic       b_str_end;  // string close: span+1
    logic       eof_valid;
  } work_t;

  localparam logic [1:0] LEN_ZERO = 2'd0;
  localparam logic [1:0] LEN_ONE  = 2'd1;
  localparam logic [1:0] LEN_TWO  = 2'd2;
  localparam logic [1:0] LEN_SPAN = 2'd3;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [63:0] pack_word(input logic [7:0] w [8]);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) r[8*i +: 8] = w[i];
    return r;
  endfunction

  // Keyword lookup on the first eight identifier bytes, byte 0 in the low lane.
  function automatic logic [5:0] word_type(input logic [63:0] w, input logic [3:0] n);
    logic [5:0] t;
    t = T_IDENT;
    unique case (n)
      4'd2: begin
        if (w[15:0] == 16'h6669) t = 6'd31;      // if
        else if (w[15:0] == 16'h726f) t = 6'd33; // or
      end
      4'd3: begin
        if (w[23:0] == 24'h646e61) t = 6'd26;      // and
        else if (w[23:0] == 24'h726f66) t = 6'd29; // for
        else if (w[23:0] == 24'h6e7566) t = 6'd30; // fun
        else if (w[23:0] == 24'h6c696e) t = 6'd32; // nil
        else if (w[23:0] == 24'h726176) t = 6'd36; // var
      end
      4'd4: begin
        if (w[31:0] == 32'h65736c65) t = 6'd27;      // else
        else if (w[31:0] == 32'h65757274) t = 6'd35; // true
      end
      4'd5: begin
        if (w[39:0] == 40'h65736c6166) t = 6'd28;      // false
        else if (w[39:0] == 40'h656c696877) t = 6'd37; // while
        else if (w[39:0] == 40'h6b61657262) t = 6'd38; // break
      end
      4'd6: if (w[47:0] == 48'h6e7275746572) t = 6'd34;  // return
      4'd8: if (w == 64'h65756e69746e6f63) t = 6'd39;    // continue
      default: t = T_IDENT;
    endcase
    return t;
  endfunction

endpackage

// File: rtl/core/source_token_scanner.sv
// Top level of the source token scanner: front end, work queue, back end.
// Depends on sts_pkg, sts_front, sts_fifo, sts_back and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Takes one source byte per cycle and emits token records. The front end
// accepts a byte every cycle unless the four-entry work queue is full; each
// byte yields zero to three records, and the back end sends them one at a
// time through a registered output, dropping a byte with none from the queue.
// Input runs at one byte per cycle while bytes average at most one record and
// the output is not stalled, and slows to the record rate otherwise. A record
// reaches the output ports through the work queue and the output register.
module source_token_scanner #(
  parameter int unsigned OffsetBits = sts_pkg::OffsetBitsDef,
  parameter int unsigned LineBits   = sts_pkg::LineBitsDef,
  parameter int unsigned DepthBits  = sts_pkg::DepthBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  sts_pkg::in_item_t  in_item_i,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output sts_pkg::out_item_t out_item_o
);

  localparam int unsigned WW = $bits(sts_pkg::work_t) + 2*OffsetBits + 2*LineBits;

  sts_pkg::work_t        f_work, b_work;
  logic [OffsetBits-1:0] f_beg, f_pos, b_beg, b_pos;
  logic [LineBits-1:0]   f_line, f_lnext, b_line, b_lnext;
  logic                  q_full, q_empty, take, step, out_v;

  assign step = push && !q_full;
  assign full = q_full;

  sts_front #(.OffsetBits(OffsetBits), .LineBits(LineBits), .DepthBits(DepthBits)) u_front (
    .clk_i, .rst_ni, .step_i(step), .item_i(in_item_i), .work_o(f_work),
    .begin_o(f_beg), .pos_o(f_pos), .line_o(f_line), .line_next_o(f_lnext)
  );

  sts_fifo #(.Width(WW), .Depth(4)) u_queue (
    .clk_i, .rst_ni, .push_i(step),
    .data_i({f_work, f_beg, f_pos, f_line, f_lnext}), .full_o(q_full),
    .pop_i(take), .data_o({b_work, b_beg, b_pos, b_line, b_lnext}), .empty_o(q_empty)
  );

  sts_back #(.OffsetBits(OffsetBits), .LineBits(LineBits)) u_back (
    .clk_i, .rst_ni, .avail_i(!q_empty), .work_i(b_work), .begin_i(b_beg), .pos_i(b_pos),
    .line_i(b_line), .line_b_i(b_lnext), .take_o(take), .valid_o(out_v),
    .item_o(out_item_o), .ready_i(pop)
  );

  assign empty = !out_v;

  `SCN_ASSERT(a_take_needs_work, clk_i, rst_ni, take |-> !q_empty, "queue popped while empty")
  `SCN_ASSERT(a_stall_holds, clk_i, rst_ni, (out_v && !pop) |=> $stable(out_item_o), "result changed under stall")
  `SCN_NEVER(a_no_push_full, clk_i, rst_ni, step && q_full, "queue written while full")

endmodule

// File: rtl/core/sts_front.sv
// Front end: scan state machine, one byte per cycle when stepped, classifies each byte.
// Depends on sts_pkg. Sends a work descriptor plus positions to the back end.
`timescale 1ns / 1ps
module sts_front #(
  parameter int unsigned OffsetBits = sts_pkg::OffsetBitsDef,
  parameter int unsigned LineBits   = sts_pkg::LineBitsDef,
  parameter int unsigned DepthBits  = sts_pkg::DepthBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  sts_pkg::in_item_t     item_i,
  output sts_pkg::work_t        work_o,
  output logic [OffsetBits-1:0] begin_o,
  output logic [OffsetBits-1:0] pos_o,
  output logic [LineBits-1:0]   line_o,
  output logic [LineBits-1:0]   line_next_o
);

  localparam logic [OffsetBits-1:0] OffMax = '1;
  localparam logic [LineBits-1:0]   LinMax = '1;
  localparam logic [DepthBits-1:0]  DepMax = '1;

  sts_pkg::mode_e         mode_q, mode_d;
  logic [OffsetBits-1:0]  begin_q, begin_d, pos_q;
  logic [LineBits-1:0]    line_q, line_d;
  logic [7:0]             word_q [8];
  logic [3:0]             wlen_q, wlen_d;
  logic [DepthBits-1:0]   depth_q, depth_d;
  logic [1:0]             pair_q, pair_d;
  logic                   esc_q, esc_d;
  logic                   wr_word, wr_first;
  sts_pkg::work_t         w;

  logic [7:0] c;
  logic       fin, restart, nl;
  logic [5:0] hold_type;

  always_comb begin
    c = item_i.char_byte;
    fin = item_i.end_of_input || (c == 8'h00);
  end

  // Type of a pending token that a flush would complete.
  always_comb begin
    unique case (mode_q)
      sts_pkg::M_IDENT: hold_type = sts_pkg::word_type(sts_pkg::pack_word(word_q), wlen_q);
      sts_pkg::M_BANG:  hold_type = sts_pkg::T_BANG;
      sts_pkg::M_EQ:    hold_type = sts_pkg::T_EQUAL;
      sts_pkg::M_LT:    hold_type = sts_pkg::T_LESS;
      sts_pkg::M_GT:    hold_type = sts_pkg::T_GREATER;
      sts_pkg::M_SLASH: hold_type = sts_pkg::T_SLASH;
      sts_pkg::M_STR:   hold_type = sts_pkg::T_ERROR;
      default:          hold_type = sts_pkg::T_NUMBER;
    endcase
  end

  // Next state and work descriptor.
  always_comb begin
    mode_d = mode_q;
    begin_d = begin_q;
    line_d = line_q;
    wlen_d = wlen_q;
    depth_d = depth_q;
    pair_d = pair_q;
    esc_d = esc_q;
    wr_word = 1'b0;
    wr_first = 1'b0;
    restart = 1'b0;
    nl = 1'b0;
    w = '0;
    if (mode_q == sts_pkg::M_DONE) begin
      w.eof_valid = 1'b1;
    end else if (fin) begin
      w.eof_valid = 1'b1;
      mode_d = sts_pkg::M_DONE;
      if (mode_q != sts_pkg::M_IDLE && mode_q != sts_pkg::M_LINEC &&
          mode_q != sts_pkg::M_BLOCKC) begin
        w.ev_valid = 1'b1;
        w.a_type = hold_type;
        w.a_use_begin = 1'b1;
        w.a_err = (mode_q == sts_pkg::M_STR) ? sts_pkg::ERR_UNTERM : sts_pkg::ERR_NONE;
        w.a_len_kind = (mode_q == sts_pkg::M_STR) ? sts_pkg::LEN_ZERO :
                       (mode_q == sts_pkg::M_IDENT || mode_q == sts_pkg::M_INT ||
                        mode_q == sts_pkg::M_FRAC || mode_q == sts_pkg::M_DOT) ?
                       sts_pkg::LEN_SPAN : sts_pkg::LEN_ONE;
        w.a_dot_split = (mode_q == sts_pkg::M_DOT);
        w.dot_valid = (mode_q == sts_pkg::M_DOT);
      end
    end else begin
      unique case (mode_q)
        sts_pkg::M_IDLE: restart = 1'b1;
        sts_pkg::M_IDENT: begin
          if (sts_pkg::is_alpha(c) || sts_pkg::is_digit(c)) begin
            wr_word = (wlen_q < 4'd8);
            if (wlen_q < 4'd9) wlen_d = wlen_q + 4'd1;
          end else restart = 1'b1;
        end
        sts_pkg::M_INT: begin
          if (c == 8'h2e) mode_d = sts_pkg::M_DOT;
          else if (!sts_pkg::is_digit(c)) restart = 1'b1;
        end
        sts_pkg::M_DOT: begin
          if (sts_pkg::is_digit(c)) mode_d = sts_pkg::M_FRAC;
          else restart = 1'b1;
        end
        sts_pkg::M_FRAC: if (!sts_pkg::is_digit(c)) restart = 1'b1;
        sts_pkg::M_STR: begin
          if (esc_q) esc_d = 1'b0;
          else if (c == 8'h22) begin
            mode_d = sts_pkg::M_IDLE;
            w.b_valid = 1'b1;
            w.b_type = sts_pkg::T_STRING;
            w.b_len_kind = sts_pkg::LEN_SPAN;
            w.b_str_end = 1'b1;
          end else begin
            nl = (c == 8'h0a);
            if (c == 8'h5c) esc_d = 1'b1;
          end
        end
        sts_pkg::M_LINEC: begin
          if (c == 8'h0a) begin
            nl = 1'b1;
            mode_d = sts_pkg::M_IDLE;
          end
        end
        sts_pkg::M_BLOCKC: begin
          pair_d = 2'd0;
          if (pair_q == 2'd1 && c == 8'h2a) begin
            if (depth_q < DepMax) depth_d = depth_q + 1'b1;
          end else if (pair_q == 2'd2 && c == 8'h2f) begin
            if (depth_q > '0) depth_d = depth_q - 1'b1;
            if (depth_q <= {{(DepthBits-1){1'b0}}, 1'b1}) mode_d = sts_pkg::M_IDLE;
          end else if (c == 8'h2f) pair_d = 2'd1;
          else if (c == 8'h2a) pair_d = 2'd2;
          else nl = (c == 8'h0a);
        end
        sts_pkg::M_SLASH: begin
          if (c == 8'h2f) mode_d = sts_pkg::M_LINEC;
          else if (c == 8'h2a) begin
            mode_d = sts_pkg::M_BLOCKC;
            depth_d = {{(DepthBits-1){1'b0}}, 1'b1};
            pair_d = 2'd0;
          end else restart = 1'b1;
        end
        sts_pkg::M_BANG, sts_pkg::M_EQ, sts_pkg::M_LT, sts_pkg::M_GT: begin
          if (c == 8'h3d) begin
            mode_d = sts_pkg::M_IDLE;
            w.b_valid = 1'b1;
            w.b_type = hold_type + 6'd1;
            w.b_len_kind = sts_pkg::LEN_TWO;
          end else restart = 1'b1;
        end
        default: ;
      endcase
      if (restart) begin
        // Flush what the previous mode held, then start on this byte.
        if (mode_q != sts_pkg::M_IDLE) begin
          w.ev_valid = 1'b1;
          w.a_type = hold_type;
          w.a_use_begin = 1'b1;
          w.a_dot_split = (mode_q == sts_pkg::M_DOT);
          w.dot_valid = (mode_q == sts_pkg::M_DOT);
          w.a_len_kind = (mode_q == sts_pkg::M_SLASH || mode_q == sts_pkg::M_BANG ||
                          mode_q == sts_pkg::M_EQ || mode_q == sts_pkg::M_LT ||
                          mode_q == sts_pkg::M_GT) ? sts_pkg::LEN_ONE : sts_pkg::LEN_SPAN;
        end
        mode_d = sts_pkg::M_IDLE;
        begin_d = pos_q;
        if (sts_pkg::is_alpha(c)) begin
          mode_d = sts_pkg::M_IDENT;
          wr_first = 1'b1;
          wlen_d = 4'd1;
        end else if (sts_pkg::is_digit(c)) mode_d = sts_pkg::M_INT;
        else begin
          w.b_len_kind = sts_pkg::LEN_ONE;
          w.b_valid = 1'b1;
          case (c)
            8'h20, 8'h0d, 8'h09: w.b_valid = 1'b0;
            8'h0a: begin
              w.b_valid = 1'b0;
              nl = 1'b1;
            end
            8'h28: w.b_type = 6'd0;
            8'h29: w.b_type = 6'd1;
            8'h7b: w.b_type = 6'd2;
            8'h7d: w.b_type = 6'd3;
            8'h5b: w.b_type = 6'd4;
            8'h5d: w.b_type = 6'd5;
            8'h2c: w.b_type = 6'd6;
            8'h2e: w.b_type = 6'd7;
            8'h2d: w.b_type = 6'd8;
            8'h2b: w.b_type = 6'd9;
            8'h3b: w.b_type = 6'd10;
            8'h3a: w.b_type = 6'd11;
            8'h2a: w.b_type = 6'd13;
            8'h25: w.b_type = 6'd14;
            8'h2f: begin w.b_valid = 1'b0; mode_d = sts_pkg::M_SLASH; end
            8'h21: begin w.b_valid = 1'b0; mode_d = sts_pkg::M_BANG; end
            8'h3d: begin w.b_valid = 1'b0; mode_d = sts_pkg::M_EQ; end
            8'h3c: begin w.b_valid = 1'b0; mode_d = sts_pkg::M_LT; end
            8'h3e: begin w.b_valid = 1'b0; mode_d = sts_pkg::M_GT; end
            8'h22: begin
              w.b_valid = 1'b0;
              mode_d = sts_pkg::M_STR;
              esc_d = 1'b0;
            end
            default: begin
              w.b_type = sts_pkg::T_ERROR;
              w.b_len_kind = sts_pkg::LEN_ZERO;
              w.b_err = sts_pkg::ERR_UNEXP;
            end
          endcase
        end
      end
      if (nl && line_q != LinMax) line_d = line_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= sts_pkg::M_IDLE;
      begin_q <= '0;
      pos_q <= '0;
      line_q <= {{(LineBits-1){1'b0}}, 1'b1};
      wlen_q <= '0;
      depth_q <= '0;
      pair_q <= '0;
      esc_q <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d;
      begin_q <= begin_d;
      line_q <= line_d;
      wlen_q <= wlen_d;
      depth_q <= depth_d;
      pair_q <= pair_d;
      esc_q <= esc_d;
      if (mode_q != sts_pkg::M_DONE && !fin && pos_q != OffMax) pos_q <= pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && wr_first) word_q[0] <= c;
    else if (step_i && wr_word) word_q[wlen_q[2:0]] <= c;
  end

  assign work_o = w;
  assign begin_o = begin_q;
  assign pos_o = pos_q;
  assign line_o = line_q;
  assign line_next_o = line_d;

endmodule

// File: rtl/core/sts_fifo.sv
// Short queue between front and back ends.
// Depends on nothing but its parameters; generic payload width.
`timescale 1ns / 1ps
module sts_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wr_q, rd_q;
  logic [AW:0]      cnt_q;
  logic             do_push, do_pop;

  assign full_o = (cnt_q == (AW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop) rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

endmodule

// File: rtl/core/sts_back.sv
// Back end: expands one work descriptor into up to three token records.
// Depends on sts_pkg. One record per cycle to the output register while the output is not stalled.
`timescale 1ns / 1ps
module sts_back #(
  parameter int unsigned OffsetBits = sts_pkg::OffsetBitsDef,
  parameter int unsigned LineBits   = sts_pkg::LineBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  avail_i,
  input  sts_pkg::work_t        work_i,
  input  logic [OffsetBits-1:0] begin_i,
  input  logic [OffsetBits-1:0] pos_i,
  input  logic [LineBits-1:0]   line_i,
  input  logic [LineBits-1:0]   line_b_i,
  output logic                  take_o,
  output logic                  valid_o,
  output sts_pkg::out_item_t    item_o,
  input  logic                  ready_i
);

  localparam int unsigned FO = sts_pkg::FieldOffBits;
  localparam int unsigned FL = sts_pkg::FieldLineBits;

  logic [1:0] done_q, done_d;  // records already sent of this work item
  logic [3:0] present;         // slots in order a, dot, b, eof
  logic [2:0] need;
  logic [1:0] sel, seen;
  logic       found;
  logic       last, fire;
  logic [OffsetBits-1:0] dotp, st, len, spn, spn_end, str_spn;
  logic [LineBits-1:0]   ln;
  logic [5:0] typ;
  logic [1:0] err;
  logic       out_v_q;
  sts_pkg::out_item_t out_q;

  function automatic logic [FO-1:0] sat_off(input logic [OffsetBits-1:0] v);
    logic [FO-1:0] r;
    if (OffsetBits > FO) r = (v > OffsetBits'({FO{1'b1}})) ? '1 : FO'(v);
    else r = FO'(v);
    return r;
  endfunction

  function automatic logic [FL-1:0] sat_line(input logic [LineBits-1:0] v);
    logic [FL-1:0] r;
    if (LineBits > FL) r = (v > LineBits'({FL{1'b1}})) ? '1 : FL'(v);
    else r = FL'(v);
    return r;
  endfunction

  always_comb begin
    present = {work_i.eof_valid, work_i.b_valid, work_i.dot_valid, work_i.ev_valid};
    need = {2'b0, present[0]} + {2'b0, present[1]} + {2'b0, present[2]} +
           {2'b0, present[3]};
    // Pick the record index done_q among the present ones in order a, dot, b, eof.
    sel = 2'd3;
    seen = 2'd0;
    found = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (present[i] && !found) begin
        if (seen == done_q) begin
          sel = 2'(i);
          found = 1'b1;
        end
        seen = seen + 2'd1;
      end
    end
    last = ({1'b0, done_q} + 3'd1 >= need);
    dotp = (pos_i != '0) ? pos_i - 1'b1 : '0;
    spn_end = work_i.a_dot_split ? dotp : pos_i;
    spn = (spn_end > begin_i) ? spn_end - begin_i : '0;
    str_spn = (pos_i > begin_i) ? pos_i - begin_i : '0;
    st = pos_i;
    len = '0;
    typ = sts_pkg::T_EOF;
    err = sts_pkg::ERR_NONE;
    ln = line_b_i;
    case (sel)
      2'd0: begin
        typ = work_i.a_type;
        err = work_i.a_err;
        st = begin_i;
        ln = line_i;
        case (work_i.a_len_kind)
          sts_pkg::LEN_ZERO: len = '0;
          sts_pkg::LEN_ONE:  len = OffsetBits'(1);
          sts_pkg::LEN_TWO:  len = OffsetBits'(2);
          default:           len = spn;
        endcase
      end
      2'd1: begin
        typ = sts_pkg::T_DOT;
        st = dotp;
        len = OffsetBits'(1);
        ln = line_i;
      end
      2'd2: begin
        typ = work_i.b_type;
        err = work_i.b_err;
        st = (work_i.b_str_end || work_i.b_len_kind == sts_pkg::LEN_TWO) ? begin_i : pos_i;
        case (work_i.b_len_kind)
          sts_pkg::LEN_ZERO: len = '0;
          sts_pkg::LEN_ONE:  len = OffsetBits'(1);
          sts_pkg::LEN_TWO:  len = OffsetBits'(2);
          default:           len = (str_spn == '1) ? '1 : str_spn + 1'b1;
        endcase
      end
      default: ;
    endcase
  end

  assign fire = avail_i && (need != 3'd0) && (!out_v_q || ready_i);
  assign take_o = avail_i && ((need == 3'd0) || (fire && last));
  assign done_d = take_o ? 2'd0 : fire ? done_q + 2'd1 : done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      done_q <= done_d;
      if (fire) out_v_q <= 1'b1;
      else if (ready_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q.token_type <= typ;
      out_q.start_offset <= sat_off(st);
      out_q.token_length <= sat_off(len);
      out_q.line_number <= sat_line(ln);
      out_q.error_kind <= err;
      out_q.last_of_run <= last;
    end
  end

  assign valid_o = out_v_q;
  assign item_o = out_q;

endmodule
